// ===== design/hoare_quicksort_engine_core_macros.svh =====
// Assertion macros used by the checker file
`ifndef HOARE_QUICKSORT_ENGINE_CORE_MACROS_SVH
`define HOARE_QUICKSORT_ENGINE_CORE_MACROS_SVH
`define HQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/hqs_pkg.sv =====
// Package: types and constants of the quicksort engine
package hqs_pkg;
    localparam int unsigned MaxItemsDefault = 64;
    localparam int unsigned AddrW = 6;
    localparam int unsigned CountW = 7;
    localparam int unsigned DataW = 32;

    typedef enum logic [3:0] {
        ST_LOAD, ST_START, ST_POP, ST_POPWAIT, ST_PIVRD, ST_PIVWAIT,
        ST_SCANI, ST_SCANJ, ST_SWAP, ST_PUSH, ST_SCANRD,
        ST_OUTRD, ST_OUTWAIT, ST_OUTHOLD
    } t_state;

    function automatic logic key_lt(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
        key_lt = $signed(a) < $signed(b);
    endfunction
endpackage

// ===== design/hoare_quicksort_engine_core.sv =====
// Top level: loads a set, sorts it in place with Hoare quicksort, streams it out.
// Loading accepts a word whenever i_valid is high in the load state. The cycle after
// the last word the block starts sorting the stored set in one single-port element
// memory (one read or write per cycle) using a range stack memory. Each popped range
// passes the pop, pop-wait, pivot-read and pivot-wait states before scanning starts,
// scanning steps over one element at a time, left scan first and then right scan,
// each swap writes both elements and rereads element i when scanning goes on, and
// closing a partition pushes the left and then the right subrange. The sort is
// quadratic in the worst case. Each output word is read, registered and then held
// until the receiver is ready, so a stall holds the word. No input is taken while sorting or emitting.
module hoare_quicksort_engine_core
    import hqs_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MaxItemsDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [31:0] i_value,
    input  logic              i_is_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [31:0] o_sorted_value,
    output logic              o_run_last,
    output logic              o_overflowed
);
    logic [DataW-1:0] r_mem [0:63];
    logic [DataW-1:0] r_rd;
    logic [11:0] r_stk [0:63];
    logic [11:0] r_srd;

    t_state r_state, n_state;
    logic [CountW-1:0] r_count, r_sp;
    logic r_drop;
    logic [AddrW-1:0] r_l, r_r, r_i, r_j, r_k;
    logic [DataW-1:0] r_piv, r_vi;
    logic r_ioob, r_jneg;  // i past end / j below zero markers
    logic r_push2;
    logic [DataW-1:0] r_out;
    logic r_olast;

    logic acc;
    assign o_ready = (r_state == ST_LOAD);
    assign acc = i_valid && o_ready;

    // memory port control
    logic mem_we;
    logic [AddrW-1:0] mem_a;
    logic [DataW-1:0] mem_wd;
    logic stk_we;
    logic [AddrW-1:0] stk_a;
    logic [11:0] stk_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_a] <= mem_wd;
        r_rd <= r_mem[mem_a];
        if (stk_we) r_stk[stk_a] <= stk_wd;
        r_srd <= r_stk[stk_a];
    end

    // compare helpers
    logic i_go, j_go, swap_more;
    assign i_go = (r_i < r_r) && key_lt(r_rd, r_piv);
    assign j_go = (r_j > r_l) && key_lt(r_piv, r_rd);
    assign swap_more = (r_i != r_r) && (r_j != '0) && ((r_i + 1'b1) <= (r_j - 1'b1));

    logic swap_w2;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:    if (acc && i_is_last) n_state = ST_START;
            ST_START:   n_state = (r_count < CountW'(2)) ? ST_OUTRD : ST_POP;
            ST_POP:     n_state = (r_sp == '0) ? ST_OUTRD : ST_POPWAIT;
            ST_POPWAIT: n_state = ST_PIVRD;
            ST_PIVRD:   n_state = (r_srd[5:0] >= r_srd[11:6]) ? ST_POP : ST_PIVWAIT;
            ST_PIVWAIT: n_state = ST_SCANI;
            ST_SCANI:   n_state = (!r_ioob && i_go) ? ST_SCANI : ST_SCANJ;
            ST_SCANJ:   n_state = j_go ? ST_SCANJ : ST_SWAP;
            ST_SWAP:    n_state = ST_PUSH;
            ST_PUSH: begin
                if (swap_w2) n_state = swap_more ? ST_SCANRD : ST_PUSH;
                else if (r_push2) n_state = ST_POP;
                else n_state = ST_PUSH;
            end
            ST_SCANRD:  n_state = ST_SCANI;
            ST_OUTRD:   n_state = ST_OUTWAIT;
            ST_OUTWAIT: n_state = ST_OUTHOLD;
            ST_OUTHOLD: begin
                if (i_ready) n_state = r_olast ? ST_LOAD : ST_OUTRD;
            end
            default:    n_state = ST_LOAD;
        endcase
    end

    // sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_sp <= '0;
            r_drop <= 1'b0;
            swap_w2 <= 1'b0;
            r_push2 <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_LOAD: begin
                    if (acc) begin
                        if (r_count < CountW'(MAX_ITEMS)) r_count <= r_count + 1'b1;
                        else r_drop <= 1'b1;
                    end
                end
                ST_START: begin
                    r_sp <= CountW'(1);
                    r_k <= '0;
                end
                ST_POP: begin
                    if (r_sp != '0) r_sp <= r_sp - 1'b1;
                end
                ST_PIVRD: begin
                    r_l <= r_srd[5:0];
                    r_r <= r_srd[11:6];
                    r_i <= r_srd[5:0];
                    r_j <= r_srd[11:6];
                    r_ioob <= 1'b0;
                    r_jneg <= 1'b0;
                end
                ST_PIVWAIT: r_piv <= r_rd;
                ST_SCANI: begin
                    if (!r_ioob && i_go) r_i <= r_i + 1'b1;
                    else r_vi <= r_rd;
                end
                ST_SCANJ: begin
                    if (j_go) r_j <= r_j - 1'b1;
                end
                ST_SWAP: begin
                    // r_rd holds element j; i<=j check
                    if (!r_jneg && r_i <= r_j) swap_w2 <= 1'b1;
                    else r_push2 <= 1'b0;
                end
                ST_PUSH: begin
                    if (swap_w2) begin
                        swap_w2 <= 1'b0;
                        if (r_i == r_r) r_ioob <= 1'b1;
                        else r_i <= r_i + 1'b1;
                        if (r_j == '0) r_jneg <= 1'b1;
                        else r_j <= r_j - 1'b1;
                    end else if (!r_push2) begin
                        if (!r_jneg && r_l < r_j) r_sp <= r_sp + 1'b1;
                        r_push2 <= 1'b1;
                    end else begin
                        if (r_ioob ? 1'b0 : (r_i < r_r)) r_sp <= r_sp + 1'b1;
                        r_push2 <= 1'b0;
                    end
                end
                ST_OUTWAIT: begin
                    r_out <= r_rd;
                    r_olast <= ({1'b0, r_k} == r_count - 1'b1);
                end
                ST_OUTHOLD: begin
                    if (i_ready) begin
                        if (r_olast) begin
                            r_count <= '0;
                            r_drop <= 1'b0;
                            r_sp <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // memory addressing per state
    always_comb begin
        mem_we = 1'b0;
        mem_a = r_i;
        mem_wd = r_rd;
        stk_we = 1'b0;
        stk_a = r_sp[AddrW-1:0] - 1'b1;
        stk_wd = {r_r, r_l};
        unique case (r_state)
            ST_LOAD: begin
                mem_a = r_count[AddrW-1:0];
                mem_wd = i_value;
                mem_we = acc && (r_count < CountW'(MAX_ITEMS));
            end
            ST_START: begin
                stk_a = '0;
                stk_we = 1'b1;
                stk_wd = {AddrW'(r_count - 1'b1), AddrW'(0)};
            end
            ST_POPWAIT: stk_a = r_sp[AddrW-1:0];
            ST_PIVRD: mem_a = AddrW'(({1'b0, r_srd[5:0]} + {1'b0, r_srd[11:6]}) >> 1);
            ST_PIVWAIT: mem_a = r_i;
            ST_SCANI: mem_a = (!r_ioob && i_go) ? r_i + 1'b1 : r_j;
            ST_SCANJ: mem_a = j_go ? r_j - 1'b1 : r_j;
            ST_SWAP: begin
                mem_a = r_i;
                mem_wd = r_rd;
                mem_we = !r_jneg && r_i <= r_j;
            end
            ST_PUSH: begin
                if (swap_w2) begin
                    mem_a = r_j;
                    mem_wd = r_vi;
                    mem_we = 1'b1;
                end else if (!r_push2) begin
                    stk_a = r_sp[AddrW-1:0];
                    stk_wd = {r_j, r_l};
                    stk_we = !r_jneg && r_l < r_j;
                end else begin
                    stk_a = r_sp[AddrW-1:0];
                    stk_wd = {r_r, r_i};
                    stk_we = !r_ioob && r_i < r_r;
                end
            end
            ST_SCANRD: mem_a = r_i;
            ST_OUTRD: mem_a = r_k;
            default: ;
        endcase
    end

    assign o_valid = (r_state == ST_OUTHOLD);
    assign o_sorted_value = r_out;
    assign o_run_last = r_olast;
    assign o_overflowed = r_drop;
endmodule

// ===== design/hqs_checker.sv =====
// Checker: port-level assertions for the quicksort engine, with bind
`include "hoare_quicksort_engine_core_macros.svh"
module hqs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_run_last,
    input logic o_overflowed,
    input logic [31:0] o_sorted_value
);
    logic [33:0] out_word;
    assign out_word = {o_sorted_value, o_run_last, o_overflowed};

    `HQS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `HQS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(out_word))
    `HQS_ASSERT_NXT(a_reload, i_clk, i_rst_n, o_valid && i_ready && o_run_last, o_ready)
endmodule

bind hoare_quicksort_engine_core hqs_checker u_hqs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_run_last(o_run_last),
    .o_overflowed(o_overflowed), .o_sorted_value(o_sorted_value)
);
